// ===== hw/rtl/tmcw_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tmcw_pkg
// shared types and constants of the text mode console writer
// ----------------------------------------------------------------------------
package tmcw_pkg;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    localparam int FUNC_W   = 2;
    localparam int BYTE_W   = 8;
    localparam int COL_IN_W = 7;
    localparam int ROW_IN_W = 5;
    localparam int CELL_W   = 16;
    localparam int CURSOR_W = 11;

    localparam logic [BYTE_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [BYTE_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [BYTE_W-1:0] CH_SPACE     = 8'd32;
    localparam logic [BYTE_W-1:0] RESET_ATTR   = 8'd15;

    typedef enum logic [FUNC_W-1:0] {
        OP_PUT   = 2'd0,
        OP_MOVE  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    // controller to datapath
    typedef struct packed {
        logic latch;     // take the input word
        logic exec;      // perform the operation of the latched word
        logic copy;      // one step of the scroll copy
        logic blank;     // one blanking step with the current default attribute
        logic init;      // one blanking step of the power-up sweep
        logic load_out;  // load the result register
    } tmcw_cmd_t;

    // datapath to controller
    typedef struct packed {
        op_t  op;
        logic need_scroll;
        logic ptr_last;
        logic copy_last;
        logic out_free;
    } tmcw_sts_t;

endpackage
`default_nettype wire

// ===== hw/rtl/tmcw_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tmcw_ctrl
// sequencer of the console writer: sweeps, operations and result handoff
// ----------------------------------------------------------------------------
module tmcw_ctrl
    import tmcw_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      s_tvalid,
    output logic           s_tready,
    input  wire tmcw_sts_t sts,
    output tmcw_cmd_t      cmd
);

    typedef enum logic [5:0] {
        ST_INIT  = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_EXEC  = 6'b000100,
        ST_COPY  = 6'b001000,
        ST_BLANK = 6'b010000,
        ST_RESP  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_INIT:
            begin
                cmd.init = 1'b1;
                if (sts.ptr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                unique case (sts.op)
                    OP_CLEAR: state_next = ST_BLANK;
                    OP_READ:  state_next = ST_RESP;
                    OP_PUT, OP_MOVE:
                    begin
                        if (sts.op == OP_PUT && sts.need_scroll)
                        begin
                            state_next = ST_COPY;
                        end
                        else if (sts.out_free)
                        begin
                            cmd.load_out = 1'b1;
                            state_next   = ST_IDLE;
                        end
                        else
                        begin
                            state_next = ST_RESP;
                        end
                    end
                    default: state_next = ST_RESP;
                endcase
            end
            ST_COPY:
            begin
                cmd.copy = 1'b1;
                if (sts.copy_last)
                begin
                    state_next = ST_BLANK;
                end
            end
            ST_BLANK:
            begin
                cmd.blank = 1'b1;
                if (sts.ptr_last)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== hw/rtl/tmcw_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tmcw_dp
// datapath: screen store, cursor, sweep pointer and result register
// ----------------------------------------------------------------------------
module tmcw_dp
    import tmcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire tmcw_cmd_t           cmd,
    output tmcw_sts_t                sts,
    input  wire logic [FUNC_W-1:0]   func,
    input  wire logic [BYTE_W-1:0]   char_code,
    input  wire logic [BYTE_W-1:0]   attr,
    input  wire logic [COL_IN_W-1:0] col,
    input  wire logic [ROW_IN_W-1:0] row,
    input  wire logic                cfg_valid,
    input  wire logic [BYTE_W-1:0]   cfg_data,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [CURSOR_W-1:0]      cursor_cell,
    output logic [BYTE_W-1:0]        read_char,
    output logic [BYTE_W-1:0]        read_attr,
    output logic                     scrolled
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int COL_W = $clog2(COLUMNS);
    localparam int ROW_W = $clog2(ROWS);

    // screen store, char in the low byte, attribute in the high byte
    logic [CELL_W-1:0] mem [CELLS];

    op_t               op_reg;
    logic [BYTE_W-1:0] char_reg;
    logic [BYTE_W-1:0] attr_reg;
    logic [COL_W-1:0]  col_in_reg;
    logic [ROW_W-1:0]  row_in_reg;

    logic [COL_W-1:0]  cur_col_reg;
    logic [COL_W-1:0]  cur_col_next;
    logic [ROW_W-1:0]  cur_line_reg;
    logic [ROW_W-1:0]  cur_line_next;
    logic [AW-1:0]     ptr_reg;
    logic [CELL_W-1:0] rd_data_reg;
    logic              scrolled_reg;
    logic [BYTE_W-1:0] default_attr_reg;

    logic              out_valid_reg;
    logic [CURSOR_W-1:0] out_cursor_reg;
    logic [BYTE_W-1:0] out_char_reg;
    logic [BYTE_W-1:0] out_attr_reg;
    logic              out_scrolled_reg;

    logic [COL_W-1:0]  col_c;
    logic [ROW_W-1:0]  row_c;
    logic [BYTE_W-1:0] eff_attr;
    logic [COL_W:0]    col_inc;
    logic [ROW_W:0]    line_inc;
    logic [COL_W-1:0]  put_col;
    logic [ROW_W:0]    put_line;
    logic              put_we;
    logic [AW-1:0]     put_addr;
    logic [CELL_W-1:0] put_data;
    logic              need_scroll;

    logic              we;
    logic [AW-1:0]     wr_addr;
    logic [CELL_W-1:0] wr_data;
    logic              re;
    logic [AW-1:0]     rd_addr;
    logic              copy_last;

    // clamp move/read coordinates to the screen
    always_comb
    begin
        col_c = (32'(col) > COLUMNS - 1) ? COL_W'(COLUMNS - 1) : COL_W'(col);
        row_c = (32'(row) > ROWS - 1) ? ROW_W'(ROWS - 1) : ROW_W'(row);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg     <= op_t'(func);
            char_reg   <= char_code;
            attr_reg   <= attr;
            col_in_reg <= col_c;
            row_in_reg <= row_c;
        end
    end

    assign eff_attr = (attr_reg == '0) ? default_attr_reg : attr_reg;
    assign col_inc  = {1'b0, cur_col_reg} + 1'b1;
    assign line_inc = {1'b0, cur_line_reg} + 1'b1;

    // put character: cell write and raw cursor step
    always_comb
    begin
        put_col  = cur_col_reg;
        put_line = {1'b0, cur_line_reg};
        put_we   = 1'b0;
        put_addr = AW'(32'(cur_line_reg) * COLUMNS + 32'(cur_col_reg));
        put_data = {eff_attr, char_reg};
        priority if (char_reg == CH_NEWLINE)
        begin
            put_col  = '0;
            put_line = line_inc;
        end
        else if (char_reg == CH_BACKSPACE)
        begin
            if (cur_col_reg != '0)
            begin
                put_col  = cur_col_reg - 1'b1;
                put_we   = 1'b1;
                put_addr = AW'(32'(cur_line_reg) * COLUMNS + 32'(cur_col_reg) - 1);
                put_data = {eff_attr, CH_SPACE};
            end
        end
        else
        begin
            put_we = 1'b1;
            if (32'(col_inc) >= COLUMNS)
            begin
                put_col  = '0;
                put_line = line_inc;
            end
            else
            begin
                put_col = col_inc[COL_W-1:0];
            end
        end
    end

    assign need_scroll = (32'(put_line) >= ROWS);

    always_comb
    begin
        cur_col_next  = cur_col_reg;
        cur_line_next = cur_line_reg;
        if (cmd.exec)
        begin
            unique case (op_reg)
                OP_PUT:
                begin
                    cur_col_next  = put_col;
                    cur_line_next = need_scroll ? ROW_W'(ROWS - 1) : put_line[ROW_W-1:0];
                end
                OP_MOVE:
                begin
                    cur_col_next  = col_in_reg;
                    cur_line_next = row_in_reg;
                end
                OP_CLEAR:
                begin
                    cur_col_next  = '0;
                    cur_line_next = '0;
                end
                OP_READ:
                begin
                    cur_col_next  = cur_col_reg;
                    cur_line_next = cur_line_reg;
                end
                default:
                begin
                    cur_col_next  = cur_col_reg;
                    cur_line_next = cur_line_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_col_reg      <= '0;
            cur_line_reg     <= '0;
            ptr_reg          <= '0;
            default_attr_reg <= RESET_ATTR;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            cur_col_reg  <= cur_col_next;
            cur_line_reg <= cur_line_next;
            if (cmd.latch)
            begin
                ptr_reg <= '0;
            end
            else if (cmd.copy || cmd.blank || cmd.init)
            begin
                ptr_reg <= ptr_reg + 1'b1;
            end
            if (cfg_valid)
            begin
                default_attr_reg <= cfg_data;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            scrolled_reg <= 1'b0;
        end
        else if (cmd.exec && op_reg == OP_PUT && need_scroll)
        begin
            scrolled_reg <= 1'b1;
        end
    end

    assign copy_last = (ptr_reg == AW'(CELLS - COLUMNS - 1));

    // single write port, priority by sweep kind
    always_comb
    begin
        we      = 1'b0;
        wr_addr = ptr_reg;
        wr_data = {RESET_ATTR, CH_SPACE};
        priority if (cmd.init)
        begin
            we = 1'b1;
        end
        else if (cmd.blank)
        begin
            we      = 1'b1;
            wr_data = {default_attr_reg, CH_SPACE};
        end
        else if (cmd.copy)
        begin
            we      = 1'b1;
            wr_data = rd_data_reg;
        end
        else if (cmd.exec && op_reg == OP_PUT)
        begin
            we      = put_we;
            wr_addr = put_addr;
            wr_data = put_data;
        end
    end

    // read port: cell read, or the copy source one row below
    always_comb
    begin
        re      = 1'b0;
        rd_addr = AW'(COLUMNS);
        if (cmd.exec)
        begin
            re = 1'b1;
            if (op_reg == OP_READ)
            begin
                rd_addr = AW'(32'(row_in_reg) * COLUMNS + 32'(col_in_reg));
            end
        end
        else if (cmd.copy && !copy_last)
        begin
            re      = 1'b1;
            rd_addr = AW'(32'(ptr_reg) + COLUMNS + 1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_cursor_reg   <= CURSOR_W'(32'(cur_line_next) * COLUMNS + 32'(cur_col_next));
            out_char_reg     <= (op_reg == OP_READ) ? rd_data_reg[BYTE_W-1:0] : '0;
            out_attr_reg     <= (op_reg == OP_READ) ? rd_data_reg[CELL_W-1:BYTE_W] : '0;
            out_scrolled_reg <= scrolled_reg;
        end
    end

    assign m_tvalid    = out_valid_reg;
    assign cursor_cell = out_cursor_reg;
    assign read_char   = out_char_reg;
    assign read_attr   = out_attr_reg;
    assign scrolled    = out_scrolled_reg;

    always_comb
    begin
        sts.op          = op_reg;
        sts.need_scroll = need_scroll;
        sts.ptr_last    = (ptr_reg == AW'(CELLS - 1));
        sts.copy_last   = copy_last;
        sts.out_free    = !out_valid_reg || m_tready;
    end

endmodule
`default_nettype wire

// ===== hw/rtl/text_mode_console_writer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// text_mode_console_writer
// character/attribute screen store with cursor, scroll, clear and cell read
// ----------------------------------------------------------------------------
// The console holds COLUMNS x ROWS cells of 16 bits (char low byte, attribute
// high byte) in one single-port-write, single-port-read memory, and every
// word on the input stream yields one result word with the cursor cell
// index. After reset the store is swept to blanks with attribute 15, one
// cell per cycle, and the input stream stays stalled for the whole sweep;
// configuration writes are taken during that sweep. A cell read goes
// through the registered memory read before its result is loaded. A clear
// walks the whole store once at one cell per cycle; a put that runs past
// the last row copies every row up by one (one cell per cycle through the
// read/write port pair) and then blanks the bottom row. The result
// register lets the next word be accepted while a finished result is still
// waiting.
// ----------------------------------------------------------------------------
module text_mode_console_writer
    import tmcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,

    // input stream
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [31:0]       s_tdata,   // char_code, attr, col, row, zero pad
    input  wire logic [FUNC_W-1:0] s_tuser,   // func

    // result stream
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [31:0]            m_tdata,   // cursor_cell, read_char, read_attr, zero pad
    output logic                   m_tuser,   // scrolled

    // default attribute register
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [BYTE_W-1:0] cfg_data
);

    tmcw_cmd_t cmd;
    tmcw_sts_t sts;

    logic [CURSOR_W-1:0] cursor_cell;
    logic [BYTE_W-1:0]   read_char;
    logic [BYTE_W-1:0]   read_attr;

    // register write always accepted
    assign cfg_ready = 1'b1;

    tmcw_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tmcw_dp #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .func        (s_tuser),
        .char_code   (s_tdata[7:0]),
        .attr        (s_tdata[15:8]),
        .col         (s_tdata[22:16]),
        .row         (s_tdata[27:23]),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .cursor_cell (cursor_cell),
        .read_char   (read_char),
        .read_attr   (read_attr),
        .scrolled    (m_tuser)
    );

    // result word packing, lowest field first
    assign m_tdata = {5'd0, read_attr, read_char, cursor_cell};

endmodule
`default_nettype wire
